### src/pt_pkg.sv
// Shared types and constants for the 16-bit Miller-Rabin primality tester.
// No dependencies; every other file in src except pt_rsp_if and pt_checker imports this package.
package pt_pkg;

   // Operand width of the candidate and of every residue
   localparam int unsigned VAL_W = 16;
   // Width of the factor-of-two count s (n-1 = d * 2^s, s <= 15)
   localparam int unsigned S_W   = 4;
   // Steps of the shift-add modular multiplier, one per multiplier bit
   localparam int unsigned MM_STEP_W = 4;
   localparam logic [MM_STEP_W-1:0] MM_LAST_STEP = 4'd15;

   // Witness bases
   localparam logic [VAL_W-1:0] WITNESS_A = 16'd2;
   localparam logic [VAL_W-1:0] WITNESS_B = 16'd7;
   localparam logic [VAL_W-1:0] WITNESS_C = 16'd61;

   typedef enum logic [1:0] {
      WIT_A,
      WIT_B,
      WIT_C
   } pt_wit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FACTOR,
      ST_PASS_INIT,
      ST_SQ_ISSUE,
      ST_SQ_WAIT,
      ST_MUL_ISSUE,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_LOOP_TEST,
      ST_LSQ_ISSUE,
      ST_LSQ_WAIT,
      ST_PASS_NEXT,
      ST_DONE
   } pt_state_type;

   // Command to the shared modular multiplier
   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] op_a;
      logic [VAL_W-1:0] op_b;
   } pt_mm_cmd_type;

   // Status back from the shared modular multiplier
   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] product;
   } pt_mm_stat_type;

   // Finished verdict handed from the sequencer to the output register
   typedef struct packed {
      logic valid;
      logic is_prime;
   } pt_result_type;

   function automatic logic [VAL_W-1:0] witness_value(input pt_wit_type wit);
      logic [VAL_W-1:0] val;
      unique case (wit)
         WIT_A:   val = WITNESS_A;
         WIT_B:   val = WITNESS_B;
         WIT_C:   val = WITNESS_C;
         default: val = WITNESS_A;
      endcase
      return val;
   endfunction

endpackage

### src/pt_req_if.sv
// Request channel interface: valid/ready plus the candidate number.
// Depends on pt_pkg for the operand width.
interface pt_req_if;
   import pt_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] number_to_test;

   modport source (output valid, output number_to_test, input ready);
   modport sink   (input valid, input number_to_test, output ready);
endinterface

### src/pt_rsp_if.sv
// Response channel interface: valid/ready plus the one-bit verdict.
// No dependencies beyond the language.
interface pt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

### src/primality_test_16bit.sv
// Channel      | Dir | Payload                      | Handshake
// req_chan     | in  | number_to_test [15:0] uns.   | valid/ready
// rsp_chan     | out | is_prime [0]                 | valid/ready
//
// One candidate at a time. Every modular product runs on one shift-add unit,
// one multiplier bit per cycle. A witness pass is NUM_BITS squarings, up to
// NUM_BITS base products and up to 14 more squarings; up to three passes are
// run, and zero, one and two are settled without any pass.
// Synchronous active-high reset returns the sequencer to idle, output empty.
// A held result in the output register does not stop the next request from
// being taken; a new verdict waits only if that register is still full.
// Top level: output register and channel glue around pt_ctrl and pt_modmul.
// Depends on pt_pkg, pt_req_if, pt_rsp_if, pt_modmul, pt_ctrl.
module primality_test_16bit #(
   parameter int unsigned NUM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   pt_req_if.sink     req_chan,
   pt_rsp_if.source   rsp_chan
);
   import pt_pkg::*;

   pt_mm_cmd_type    mm_cmd;
   pt_mm_stat_type   mm_stat;
   pt_result_type    result;
   logic [VAL_W-1:0] modulus;
   logic             rsp_free;
   logic             req_ready;

   logic rsp_valid_ff, rsp_valid_in;
   logic is_prime_ff, is_prime_in;

   pt_ctrl #(
      .NUM_BITS (NUM_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_number (req_chan.number_to_test),
      .req_ready  (req_ready),
      .rsp_free   (rsp_free),
      .result     (result),
      .mm_cmd     (mm_cmd),
      .modulus    (modulus),
      .mm_stat    (mm_stat)
   );

   pt_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .mm_cmd  (mm_cmd),
      .modulus (modulus),
      .mm_stat (mm_stat)
   );

   assign req_chan.ready = req_ready;

   // Output register is free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      is_prime_in  = is_prime_ff;
      if (result.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         is_prime_in  = result.is_prime;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_prime_ff <= is_prime_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_prime = is_prime_ff;

endmodule

### src/pt_modmul.sv
// Shared shift-add modular multiplier: a * b mod n, one multiplier bit per cycle.
// Depends on pt_pkg for the command and status structs.
module pt_modmul (
   input  logic                          clock,
   input  logic                          reset,
   input  pt_pkg::pt_mm_cmd_type         mm_cmd,
   input  logic [pt_pkg::VAL_W-1:0]      modulus,
   output pt_pkg::pt_mm_stat_type        mm_stat
);
   import pt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MM_STEP_W-1:0] step_ff, step_in;
   logic [VAL_W-1:0]     a_ff, a_in;
   logic [VAL_W-1:0]     b_ff, b_in;
   logic [VAL_W-1:0]     acc_ff, acc_in;

   logic [VAL_W+1:0] sum;
   logic [VAL_W+1:0] mod_x1;
   logic [VAL_W+1:0] mod_x2;
   logic [VAL_W+1:0] reduced;

   // One step: acc = 2*acc + bit*a, then fold back below n (sum < 3n)
   always_comb begin
      mod_x1 = {2'b00, modulus};
      mod_x2 = {1'b0, modulus, 1'b0};
      sum    = {1'b0, acc_ff, 1'b0} + (b_ff[VAL_W-1] ? {2'b00, a_ff} : '0);
      if (sum >= mod_x2) begin
         reduced = sum - mod_x2;
      end else if (sum >= mod_x1) begin
         reduced = sum - mod_x1;
      end else begin
         reduced = sum;
      end
   end

   // Load on start, advance one bit per cycle while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (mm_cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in    = mm_cmd.op_a;
         b_in    = mm_cmd.op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = reduced[VAL_W-1:0];
         b_in    = {b_ff[VAL_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == MM_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Operand and accumulator registers need no reset
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mm_stat.done    = done_ff;
   assign mm_stat.product = acc_ff;

endmodule

### src/pt_ctrl.sv
// Sequencer for the Miller-Rabin passes: factors n-1, runs square-and-multiply
// and the squaring loop on the shared multiplier. Depends on pt_pkg.
module pt_ctrl #(
   parameter int unsigned NUM_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [pt_pkg::VAL_W-1:0]      req_number,
   output logic                          req_ready,
   input  logic                          rsp_free,
   output pt_pkg::pt_result_type         result,
   output pt_pkg::pt_mm_cmd_type         mm_cmd,
   output logic [pt_pkg::VAL_W-1:0]      modulus,
   input  pt_pkg::pt_mm_stat_type        mm_stat
);
   import pt_pkg::*;

   // Exponent scan covers NUM_BITS bits; d itself never exceeds 16 bits
   localparam int unsigned EXP_W = (NUM_BITS > VAL_W) ? NUM_BITS : VAL_W;
   localparam int unsigned BIT_W = $clog2(EXP_W);
   localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(NUM_BITS - 1);
   localparam logic [VAL_W-1:0] N_MASK =
      (NUM_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((33'd1 << NUM_BITS) - 33'd1);

   pt_state_type      state_ff, state_in;
   pt_wit_type        wit_ff, wit_in;
   logic [VAL_W-1:0]  n_ff, n_in;
   logic [VAL_W-1:0]  d_ff, d_in;
   logic [S_W-1:0]    s_ff, s_in;
   logic [S_W-1:0]    k_ff, k_in;
   logic [VAL_W-1:0]  x_ff, x_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              prime_ff, prime_in;

   logic [VAL_W-1:0]  n_masked;
   logic [VAL_W-1:0]  n_minus1;
   logic [EXP_W-1:0]  d_wide;

   assign n_masked = req_number & N_MASK;
   assign n_minus1 = n_ff - 16'd1;
   assign d_wide   = EXP_W'(d_ff);
   assign modulus  = n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers of the sequencer carry no reset
   always_ff @(posedge clock) begin
      wit_ff   <= wit_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      s_ff     <= s_in;
      k_ff     <= k_in;
      x_ff     <= x_in;
      bit_ff   <= bit_in;
      prime_ff <= prime_in;
   end

   always_comb begin
      state_in        = state_ff;
      wit_in          = wit_ff;
      n_in            = n_ff;
      d_in            = d_ff;
      s_in            = s_ff;
      k_in            = k_ff;
      x_in            = x_ff;
      bit_in          = bit_ff;
      prime_in        = prime_ff;
      req_ready       = 1'b0;
      result.valid    = 1'b0;
      result.is_prime = prime_ff;
      mm_cmd.start    = 1'b0;
      mm_cmd.op_a     = x_ff;
      mm_cmd.op_b     = x_ff;

      unique case (state_ff)
         // Take a transaction; settle zero, one and two at once
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in = n_masked;
               if (n_masked <= 16'd1) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else if (n_masked == 16'd2) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  d_in     = n_masked - 16'd1;
                  s_in     = '0;
                  state_in = ST_FACTOR;
               end
            end
         end

         // Strip one factor of two per cycle
         ST_FACTOR: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[VAL_W-1:1]};
               s_in = s_ff + 1'b1;
            end else begin
               wit_in   = WIT_A;
               state_in = ST_PASS_INIT;
            end
         end

         ST_PASS_INIT: begin
            x_in     = 16'd1;
            bit_in   = TOP_BIT;
            state_in = ST_SQ_ISSUE;
         end

         ST_SQ_ISSUE: begin
            mm_cmd.start = 1'b1;
            state_in     = ST_SQ_WAIT;
         end

         // After the square, multiply by the base if this exponent bit is set
         ST_SQ_WAIT: begin
            if (mm_stat.done) begin
               x_in = mm_stat.product;
               if (d_wide[bit_ff]) begin
                  state_in = ST_MUL_ISSUE;
               end else if (bit_ff == '0) begin
                  state_in = ST_CHECK;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = ST_SQ_ISSUE;
               end
            end
         end

         ST_MUL_ISSUE: begin
            mm_cmd.start = 1'b1;
            mm_cmd.op_b  = witness_value(wit_ff);
            state_in     = ST_MUL_WAIT;
         end

         ST_MUL_WAIT: begin
            if (mm_stat.done) begin
               x_in = mm_stat.product;
               if (bit_ff == '0) begin
                  state_in = ST_CHECK;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = ST_SQ_ISSUE;
               end
            end
         end

         ST_CHECK: begin
            if (x_ff == 16'd1) begin
               state_in = ST_PASS_NEXT;
            end else begin
               k_in     = {{(S_W-1){1'b0}}, 1'b1};
               state_in = ST_LOOP_TEST;
            end
         end

         // Look for n-1 between the remaining squarings
         ST_LOOP_TEST: begin
            if (x_ff == n_minus1) begin
               state_in = ST_PASS_NEXT;
            end else if (k_ff < s_ff) begin
               state_in = ST_LSQ_ISSUE;
            end else begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end
         end

         ST_LSQ_ISSUE: begin
            mm_cmd.start = 1'b1;
            state_in     = ST_LSQ_WAIT;
         end

         ST_LSQ_WAIT: begin
            if (mm_stat.done) begin
               x_in     = mm_stat.product;
               k_in     = k_ff + 1'b1;
               state_in = ST_LOOP_TEST;
            end
         end

         // Move to the next witness that is still below n, or declare prime
         ST_PASS_NEXT: begin
            if (wit_ff == WIT_A && n_ff > WITNESS_B) begin
               wit_in   = WIT_B;
               state_in = ST_PASS_INIT;
            end else if (wit_ff == WIT_B && n_ff > WITNESS_C) begin
               wit_in   = WIT_C;
               state_in = ST_PASS_INIT;
            end else begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end
         end

         // Hold the verdict until the output register can take it
         ST_DONE: begin
            result.valid = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/pt_checker.sv
// Port-level checks for primality_test_16bit, bound onto the top level.
// Depends only on the top level's port names.
module pt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_prime
);

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pending_ff, pending_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Track transactions taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No response without an outstanding request
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 2'd0)
      else $error("response with no outstanding request");

   // At most one in flight plus one held at the output
   a_bounded_pending: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> pending_ff <= 2'd1)
      else $error("request taken with two results still owed");

   // The tester works on one candidate at a time
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request side ready right after taking a candidate");

   // A stalled response keeps its verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_prime))
      else $error("stalled response dropped or changed");

endmodule

bind primality_test_16bit pt_checker u_pt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_is_prime (rsp_chan.is_prime)
);
